// ===== rtl/source_text_tokenizer_unit_assert.svh =====
// Assertion macros for the tokenizer
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

`define STOK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

`define STOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

// ===== rtl/stok_pkg.sv =====
`default_nettype none
package stok_pkg;

   localparam int IDX_W  = 24;
   localparam int LINE_W = 20;
   localparam int COL_W  = 16;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]        token_kind;
      logic [IDX_W-1:0]  start_index;
      logic [LINE_W-1:0] start_line;
      logic [COL_W-1:0]  start_col;
      logic [IDX_W-1:0]  end_index;
      logic [LINE_W-1:0] end_line;
      logic [COL_W-1:0]  end_col;
      logic [2:0]        error_code;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      rsp_type [2:0] item;
      logic [1:0]    count;
   } batch_type;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_NUMBER, MODE_WORD, MODE_STRING,
      MODE_OPER, MODE_LINE, MODE_BLOCK, MODE_DROP
   } mode_type;

   localparam logic [4:0] KIND_INT     = 5'd0;
   localparam logic [4:0] KIND_REAL    = 5'd1;
   localparam logic [4:0] KIND_WORD    = 5'd2;
   localparam logic [4:0] KIND_STRING  = 5'd3;
   localparam logic [4:0] KIND_NEWLINE = 5'd4;
   localparam logic [4:0] KIND_PLUS    = 5'd5;
   localparam logic [4:0] KIND_MINUS   = 5'd6;
   localparam logic [4:0] KIND_CARET   = 5'd7;
   localparam logic [4:0] KIND_LPAREN  = 5'd8;
   localparam logic [4:0] KIND_RPAREN  = 5'd9;
   localparam logic [4:0] KIND_LBRACE  = 5'd10;
   localparam logic [4:0] KIND_RBRACE  = 5'd11;
   localparam logic [4:0] KIND_COMMA   = 5'd12;
   localparam logic [4:0] KIND_STAR    = 5'd13;
   localparam logic [4:0] KIND_DIV     = 5'd14;
   localparam logic [4:0] KIND_ANDAND  = 5'd15;
   localparam logic [4:0] KIND_OROR    = 5'd16;
   localparam logic [4:0] KIND_ASSIGN  = 5'd17;
   localparam logic [4:0] KIND_EQ      = 5'd18;
   localparam logic [4:0] KIND_NOT     = 5'd19;
   localparam logic [4:0] KIND_NE      = 5'd20;
   localparam logic [4:0] KIND_LT      = 5'd21;
   localparam logic [4:0] KIND_LE      = 5'd22;
   localparam logic [4:0] KIND_GT      = 5'd23;
   localparam logic [4:0] KIND_GE      = 5'd24;
   localparam logic [4:0] KIND_EOF     = 5'd25;
   localparam logic [4:0] KIND_ERROR   = 5'd26;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_BAD     = 3'd1;
   localparam logic [2:0] ERR_AMP     = 3'd2;
   localparam logic [2:0] ERR_BAR     = 3'd3;
   localparam logic [2:0] ERR_COMMENT = 3'd4;
   localparam logic [2:0] ERR_STRING  = 3'd5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DQUOT = 8'h22;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SQUOT = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_LBRC  = 8'h7b;
   localparam logic [7:0] CH_BAR   = 8'h7c;
   localparam logic [7:0] CH_RBRC  = 8'h7d;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   function automatic logic [4:0] single_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         CH_PLUS:  k = KIND_PLUS;
         CH_MINUS: k = KIND_MINUS;
         CH_CARET: k = KIND_CARET;
         CH_LPAR:  k = KIND_LPAREN;
         CH_RPAR:  k = KIND_RPAREN;
         CH_LBRC:  k = KIND_LBRACE;
         CH_RBRC:  k = KIND_RBRACE;
         CH_COMMA: k = KIND_COMMA;
         CH_STAR:  k = KIND_STAR;
         default:  k = KIND_INT;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] pend_single(logic [7:0] p);
      logic [4:0] k;
      case (p)
         CH_EQ:   k = KIND_ASSIGN;
         CH_BANG: k = KIND_NOT;
         CH_LT:   k = KIND_LT;
         CH_GT:   k = KIND_GT;
         default: k = KIND_DIV;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] pend_double(logic [7:0] p);
      logic [4:0] k;
      case (p)
         CH_AMP:  k = KIND_ANDAND;
         CH_BAR:  k = KIND_OROR;
         CH_EQ:   k = KIND_EQ;
         CH_BANG: k = KIND_NE;
         CH_LT:   k = KIND_LE;
         default: k = KIND_GE;
      endcase
      return k;
   endfunction

   function automatic logic [IDX_W-1:0] sat_idx(logic [IDX_W-1:0] v, logic [1:0] d);
      logic [IDX_W:0] s;
      s = {1'b0, v} + {{(IDX_W-1){1'b0}}, d};
      return s[IDX_W] ? {IDX_W{1'b1}} : s[IDX_W-1:0];
   endfunction

   function automatic logic [LINE_W-1:0] sat_line(logic [LINE_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [COL_W-1:0] sat_col(logic [COL_W-1:0] v, logic [1:0] d);
      logic [COL_W:0] s;
      s = {1'b0, v} + {{(COL_W-1){1'b0}}, d};
      return s[COL_W] ? {COL_W{1'b1}} : s[COL_W-1:0];
   endfunction

   function automatic rsp_type make_rsp(logic [4:0] kind,
         logic [IDX_W-1:0] si, logic [LINE_W-1:0] sl, logic [COL_W-1:0] sc,
         logic [IDX_W-1:0] ei, logic [LINE_W-1:0] el, logic [COL_W-1:0] ec,
         logic [2:0] err);
      rsp_type r;
      r.token_kind  = kind;
      r.start_index = si;
      r.start_line  = sl;
      r.start_col   = sc;
      r.end_index   = ei;
      r.end_line    = el;
      r.end_col     = ec;
      r.error_code  = err;
      r.run_last    = 1'b0;
      return r;
   endfunction

   function automatic batch_type push(batch_type b, rsp_type r);
      batch_type o;
      o = b;
      case (b.count)
         2'd0: begin o.item[0] = r; o.count = 2'd1; end
         2'd1: begin o.item[1] = r; o.count = 2'd2; end
         2'd2: begin o.item[2] = r; o.count = 2'd3; end
         default: o = b;
      endcase
      return o;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/source_text_tokenizer_unit.sv =====
// channel   dir  valid       stall       payload
// req_      in   req_valid   req_stall   req_data  (text_byte, final_byte)
// rsp_      out  rsp_valid   rsp_stall   rsp_data  (token fields, run_last)
//
// One byte per cycle while req_stall is low; a byte that yields more than one
// result holds req_stall while the three-entry result buffer drains.
// First result appears the cycle after the byte transfer.
// Synchronous active-high reset returns to the start of a text at position zero.
// req_stall is high while results wait, except when the last one transfers that
// cycle, so rsp_stall on a waiting result also holds req_stall.
`default_nettype none
`include "source_text_tokenizer_unit_assert.svh"
module source_text_tokenizer_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire stok_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output stok_pkg::rsp_type       rsp_data
);

   stok_pkg::batch_type batch;
   logic                can_load;
   logic                step;

   assign req_stall = !can_load;
   assign step      = req_valid && can_load;

   stok_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .batch (batch)
   );

   stok_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .batch     (batch),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `STOK_ASSERT_IMPLY(a_stall_only_when_busy, clock, reset, req_stall, rsp_valid)
   `STOK_ASSERT_IMPLY(a_error_has_code, clock, reset,
      rsp_valid && (rsp_data.token_kind == stok_pkg::KIND_ERROR),
      rsp_data.error_code != stok_pkg::ERR_NONE)
   `STOK_ASSERT_IMPLY(a_code_only_on_error, clock, reset,
      rsp_valid && (rsp_data.token_kind != stok_pkg::KIND_ERROR),
      rsp_data.error_code == stok_pkg::ERR_NONE)
   `STOK_ASSERT_NEXT(a_final_byte_flushes, clock, reset,
      step && req_data.final_byte && (batch.count != 2'd0), rsp_valid)

endmodule
`default_nettype wire

// ===== rtl/stok_scan.sv =====
`default_nettype none
module stok_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire stok_pkg::req_type  req,
   output stok_pkg::batch_type     batch
);

   stok_pkg::mode_type            mode_ff, mode_in;
   logic                          dot_ff, dot_in;
   logic                          star_ff, star_in;
   logic [7:0]                    pend_ff, pend_in;
   logic [7:0]                    quote_ff, quote_in;
   logic [stok_pkg::IDX_W-1:0]    tsi_ff, tsi_in, ci_ff, ci_in;
   logic [stok_pkg::LINE_W-1:0]   tsl_ff, tsl_in, cl_ff, cl_in;
   logic [stok_pkg::COL_W-1:0]    tsc_ff, tsc_in, cc_ff, cc_in;

   always_comb begin
      stok_pkg::batch_type b;
      logic [7:0] c;
      logic [7:0] second;
      logic [4:0] k;
      logic do_idle;
      logic err;

      c = req.text_byte;
      b = '0;
      mode_in = mode_ff; dot_in = dot_ff; star_in = star_ff;
      pend_in = pend_ff; quote_in = quote_ff;
      tsi_in = tsi_ff; tsl_in = tsl_ff; tsc_in = tsc_ff;
      ci_in = ci_ff; cl_in = cl_ff; cc_in = cc_ff;
      do_idle = 1'b0;
      err = 1'b0;
      second = ((pend_ff == stok_pkg::CH_AMP) || (pend_ff == stok_pkg::CH_BAR)) ?
               pend_ff : stok_pkg::CH_EQ;
      k = stok_pkg::single_kind(c);

      if (c != stok_pkg::CH_NUL) begin
         case (mode_ff)
            stok_pkg::MODE_NUMBER: begin
               if (stok_pkg::is_digit(c)) begin
               end else if ((c == stok_pkg::CH_DOT) && !dot_ff) begin
                  dot_in = 1'b1;
               end else begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(
                     dot_ff ? stok_pkg::KIND_REAL : stok_pkg::KIND_INT,
                     tsi_ff, tsl_ff, tsc_ff, ci_ff, cl_ff, cc_ff, stok_pkg::ERR_NONE));
                  mode_in = stok_pkg::MODE_IDLE;
                  do_idle = 1'b1;
               end
            end
            stok_pkg::MODE_WORD: begin
               if (!(stok_pkg::is_letter(c) || (c == stok_pkg::CH_UNDER))) begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_WORD,
                     tsi_ff, tsl_ff, tsc_ff, ci_ff, cl_ff, cc_ff, stok_pkg::ERR_NONE));
                  mode_in = stok_pkg::MODE_IDLE;
                  do_idle = 1'b1;
               end
            end
            stok_pkg::MODE_STRING: begin
               if (c == quote_ff) begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_STRING,
                     tsi_ff, tsl_ff, tsc_ff, ci_ff, cl_ff, cc_ff, stok_pkg::ERR_NONE));
                  mode_in = stok_pkg::MODE_IDLE;
               end
            end
            stok_pkg::MODE_OPER: begin
               mode_in = stok_pkg::MODE_IDLE;
               if (pend_ff == stok_pkg::CH_SLASH) begin
                  if (c == stok_pkg::CH_SLASH) begin
                     mode_in = stok_pkg::MODE_LINE;
                  end else if (c == stok_pkg::CH_STAR) begin
                     mode_in = stok_pkg::MODE_BLOCK;
                     star_in = 1'b0;
                  end else begin
                     b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_DIV,
                        tsi_ff, tsl_ff, tsc_ff, stok_pkg::sat_idx(tsi_ff, 2'd1), tsl_ff,
                        stok_pkg::sat_col(tsc_ff, 2'd1), stok_pkg::ERR_NONE));
                     do_idle = 1'b1;
                  end
               end else if (c == second) begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::pend_double(pend_ff),
                     tsi_ff, tsl_ff, tsc_ff, stok_pkg::sat_idx(tsi_ff, 2'd2), tsl_ff,
                     stok_pkg::sat_col(tsc_ff, 2'd2), stok_pkg::ERR_NONE));
               end else if ((pend_ff == stok_pkg::CH_AMP) || (pend_ff == stok_pkg::CH_BAR)) begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_ERROR,
                     tsi_ff, tsl_ff, tsc_ff, ci_ff, cl_ff, cc_ff,
                     (pend_ff == stok_pkg::CH_AMP) ? stok_pkg::ERR_AMP : stok_pkg::ERR_BAR));
                  mode_in = stok_pkg::MODE_DROP;
               end else begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::pend_single(pend_ff),
                     tsi_ff, tsl_ff, tsc_ff, stok_pkg::sat_idx(tsi_ff, 2'd1), tsl_ff,
                     stok_pkg::sat_col(tsc_ff, 2'd1), stok_pkg::ERR_NONE));
                  do_idle = 1'b1;
               end
            end
            stok_pkg::MODE_LINE: begin
               if (c == stok_pkg::CH_LF) mode_in = stok_pkg::MODE_IDLE;
            end
            stok_pkg::MODE_BLOCK: begin
               if (c == stok_pkg::CH_STAR) begin
                  star_in = 1'b1;
               end else if ((c == stok_pkg::CH_SLASH) && star_ff) begin
                  star_in = 1'b0;
                  mode_in = stok_pkg::MODE_IDLE;
               end else begin
                  star_in = 1'b0;
               end
            end
            stok_pkg::MODE_IDLE: do_idle = 1'b1;
            default: begin
            end
         endcase

         if (do_idle) begin
            if (stok_pkg::is_digit(c)) begin
               mode_in = stok_pkg::MODE_NUMBER;
               dot_in = 1'b0;
               tsi_in = ci_ff; tsl_in = cl_ff; tsc_in = cc_ff;
            end else if (stok_pkg::is_letter(c)) begin
               mode_in = stok_pkg::MODE_WORD;
               tsi_in = ci_ff; tsl_in = cl_ff; tsc_in = cc_ff;
            end else if ((c == stok_pkg::CH_SPACE) || (c == stok_pkg::CH_TAB) ||
                         (c == stok_pkg::CH_CR)) begin
            end else if (c == stok_pkg::CH_LF) begin
               b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_NEWLINE,
                  ci_ff, cl_ff, cc_ff, stok_pkg::sat_idx(ci_ff, 2'd1), cl_ff,
                  stok_pkg::sat_col(cc_ff, 2'd1), stok_pkg::ERR_NONE));
            end else if (k != stok_pkg::KIND_INT) begin
               b = stok_pkg::push(b, stok_pkg::make_rsp(k,
                  ci_ff, cl_ff, cc_ff, stok_pkg::sat_idx(ci_ff, 2'd1), cl_ff,
                  stok_pkg::sat_col(cc_ff, 2'd1), stok_pkg::ERR_NONE));
            end else if ((c == stok_pkg::CH_SQUOT) || (c == stok_pkg::CH_DQUOT)) begin
               mode_in = stok_pkg::MODE_STRING;
               quote_in = c;
               tsi_in = stok_pkg::sat_idx(ci_ff, 2'd1);
               tsl_in = cl_ff;
               tsc_in = stok_pkg::sat_col(cc_ff, 2'd1);
            end else if ((c == stok_pkg::CH_SLASH) || (c == stok_pkg::CH_AMP) ||
                         (c == stok_pkg::CH_BAR) || (c == stok_pkg::CH_EQ) ||
                         (c == stok_pkg::CH_BANG) || (c == stok_pkg::CH_LT) ||
                         (c == stok_pkg::CH_GT)) begin
               mode_in = stok_pkg::MODE_OPER;
               pend_in = c;
               tsi_in = ci_ff; tsl_in = cl_ff; tsc_in = cc_ff;
            end else begin
               b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_ERROR,
                  ci_ff, cl_ff, cc_ff, stok_pkg::sat_idx(ci_ff, 2'd1), cl_ff,
                  stok_pkg::sat_col(cc_ff, 2'd1), stok_pkg::ERR_BAD));
               mode_in = stok_pkg::MODE_DROP;
            end
         end

         ci_in = stok_pkg::sat_idx(ci_ff, 2'd1);
         if (c == stok_pkg::CH_LF) begin
            cl_in = stok_pkg::sat_line(cl_ff);
            cc_in = '0;
         end else begin
            cc_in = stok_pkg::sat_col(cc_ff, 2'd1);
         end
      end

      // end of text: flush what is open, then EOF unless dropping or the flush is an error
      if ((c == stok_pkg::CH_NUL) || req.final_byte) begin
         if (mode_in != stok_pkg::MODE_DROP) begin
            case (mode_in)
               stok_pkg::MODE_NUMBER:
                  b = stok_pkg::push(b, stok_pkg::make_rsp(
                     dot_in ? stok_pkg::KIND_REAL : stok_pkg::KIND_INT,
                     tsi_in, tsl_in, tsc_in, ci_in, cl_in, cc_in, stok_pkg::ERR_NONE));
               stok_pkg::MODE_WORD:
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_WORD,
                     tsi_in, tsl_in, tsc_in, ci_in, cl_in, cc_in, stok_pkg::ERR_NONE));
               stok_pkg::MODE_STRING: begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_ERROR,
                     tsi_in, tsl_in, tsc_in, ci_in, cl_in, cc_in, stok_pkg::ERR_STRING));
                  err = 1'b1;
               end
               stok_pkg::MODE_BLOCK: begin
                  b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_ERROR,
                     tsi_in, tsl_in, tsc_in, ci_in, cl_in, cc_in, stok_pkg::ERR_COMMENT));
                  err = 1'b1;
               end
               stok_pkg::MODE_OPER: begin
                  if ((pend_in == stok_pkg::CH_AMP) || (pend_in == stok_pkg::CH_BAR)) begin
                     b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_ERROR,
                        tsi_in, tsl_in, tsc_in, ci_in, cl_in, cc_in,
                        (pend_in == stok_pkg::CH_AMP) ? stok_pkg::ERR_AMP
                                                      : stok_pkg::ERR_BAR));
                     err = 1'b1;
                  end else begin
                     b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::pend_single(pend_in),
                        tsi_in, tsl_in, tsc_in, stok_pkg::sat_idx(tsi_in, 2'd1), tsl_in,
                        stok_pkg::sat_col(tsc_in, 2'd1), stok_pkg::ERR_NONE));
                  end
               end
               default: begin
               end
            endcase
            if (!err) begin
               b = stok_pkg::push(b, stok_pkg::make_rsp(stok_pkg::KIND_EOF,
                  ci_in, cl_in, cc_in, ci_in, cl_in, cc_in, stok_pkg::ERR_NONE));
            end
         end
         mode_in = stok_pkg::MODE_DROP;
      end

      if (req.final_byte) begin
         mode_in = stok_pkg::MODE_IDLE;
         dot_in = 1'b0; star_in = 1'b0; pend_in = '0; quote_in = '0;
         tsi_in = '0; tsl_in = '0; tsc_in = '0;
         ci_in = '0; cl_in = '0; cc_in = '0;
      end

      if (b.count != 2'd0) b.item[b.count - 2'd1].run_last = 1'b1;
      batch = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stok_pkg::MODE_IDLE;
         dot_ff <= 1'b0; star_ff <= 1'b0; pend_ff <= '0; quote_ff <= '0;
         tsi_ff <= '0; tsl_ff <= '0; tsc_ff <= '0;
         ci_ff <= '0; cl_ff <= '0; cc_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         dot_ff <= dot_in; star_ff <= star_in; pend_ff <= pend_in; quote_ff <= quote_in;
         tsi_ff <= tsi_in; tsl_ff <= tsl_in; tsc_ff <= tsc_in;
         ci_ff <= ci_in; cl_ff <= cl_in; cc_ff <= cc_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/stok_outq.sv =====
`default_nettype none
module stok_outq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire stok_pkg::batch_type batch,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output stok_pkg::rsp_type        rsp_data
);

   stok_pkg::rsp_type entry_ff [3];
   logic [1:0]        head_ff;
   logic [1:0]        cnt_ff;
   logic              take;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign take      = rsp_valid && !rsp_stall;
   assign can_load  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take);
   assign rsp_data  = entry_ff[head_ff];

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff[0] <= batch.item[0];
         entry_ff[1] <= batch.item[1];
         entry_ff[2] <= batch.item[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
      end else if (load) begin
         head_ff <= '0;
         cnt_ff  <= batch.count;
      end else if (take) begin
         head_ff <= head_ff + 2'd1;
         cnt_ff  <= cnt_ff - 2'd1;
      end
   end

endmodule
`default_nettype wire
